// ===== rtl/fmpm_pkg.sv =====
package fmpm_pkg;

  localparam int NUM_CH    = 9;
  localparam int LEVEL_W   = 6;
  localparam int CH_W      = 4;
  localparam int ADDR_W    = 8;
  localparam int DATA_W    = 8;
  localparam int CFG_IDX_W = 2;
  localparam int PEAKS_W   = NUM_CH * LEVEL_W;
  localparam int KEY_BIT   = 5;

  localparam logic [ADDR_W-1:0]  KEYON_BASE  = 8'hB0;
  localparam logic [ADDR_W-1:0]  KEYON_TOP   = 8'hB8;
  localparam logic [ADDR_W-1:0]  RHYTHM_ADDR = 8'hBD;
  localparam logic [CH_W-1:0]    LAST_CH     = CH_W'(NUM_CH - 1);

  localparam logic [LEVEL_W-1:0] PEAK_FLOOR_RST = 6'd8;
  localparam logic [LEVEL_W-1:0] DECAY_STEP_RST = 6'd2;

  // carrier total-level register of each channel
  localparam logic [ADDR_W-1:0] CARRIER_TL_ADDR [NUM_CH] = '{
    8'h43, 8'h44, 8'h45, 8'h4B, 8'h4C, 8'h4D, 8'h53, 8'h54, 8'h55
  };

  typedef enum logic [1:0] {
    FUNC_WRITE = 2'd0,
    FUNC_DECAY = 2'd1,
    FUNC_MUTE  = 2'd2,
    FUNC_RSVD  = 2'd3
  } func_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PEAK_FLOOR = 2'd0,
    CFG_DECAY_STEP = 2'd1
  } cfg_idx_t;

  typedef struct packed {
    func_t               func;
    logic [ADDR_W-1:0]   reg_addr;
    logic [DATA_W-1:0]   reg_data;
    logic                mute_request;
  } in_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0]   out_reg;
    logic [DATA_W-1:0]   out_data;
    logic                out_valid;
    logic                last;
    logic [PEAKS_W-1:0]  peaks_packed;
    logic                muted_now;
  } out_item_t;

  // first result of a step plus a flag asking for the note-off burst
  typedef struct packed {
    out_item_t item;
    logic      burst;
  } step_res_t;

endpackage

// ===== rtl/fmpm_meter.sv =====
module fmpm_meter (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          adv,
  input  fmpm_pkg::in_item_t            item,
  input  logic [fmpm_pkg::LEVEL_W-1:0]  peak_floor,
  input  logic [fmpm_pkg::LEVEL_W-1:0]  decay_step,
  output fmpm_pkg::step_res_t           res
);
  import fmpm_pkg::*;

  // only the shadow bits that are ever read back are kept
  logic [NUM_CH-1:0]  key_r, key_nxt;
  logic [5:0]         bd_r, bd_nxt;
  logic [LEVEL_W-1:0] tl_r   [NUM_CH];
  logic [LEVEL_W-1:0] tl_nxt [NUM_CH];
  logic [LEVEL_W-1:0] peak_r   [NUM_CH];
  logic [LEVEL_W-1:0] peak_nxt [NUM_CH];
  logic [LEVEL_W-1:0] lvl      [NUM_CH];
  logic               muted_r, muted_nxt;
  logic [NUM_CH-1:0]  trig;
  logic [4:0]         drum_edge;
  logic               is_write, key_hit, bd_hit, burst;
  logic [PEAKS_W-1:0] peaks;

  assign is_write = item.func == FUNC_WRITE;
  assign key_hit  = is_write && item.reg_addr >= KEYON_BASE && item.reg_addr <= KEYON_TOP;
  assign bd_hit   = is_write && item.reg_addr == RHYTHM_ADDR;
  // rhythm turning on counts every set drum bit as an edge
  assign drum_edge = bd_r[KEY_BIT] ? (item.reg_data[4:0] & ~bd_r[4:0]) : item.reg_data[4:0];

  // level = 63 - attenuation, floored
  always_comb begin
    for (int i = 0; i < NUM_CH; i++) begin
      lvl[i] = (~tl_r[i] < peak_floor) ? peak_floor : ~tl_r[i];
    end
  end

  always_comb begin
    key_nxt   = key_r;
    bd_nxt    = bd_r;
    trig      = '0;
    muted_nxt = muted_r;
    burst     = 1'b0;
    for (int i = 0; i < NUM_CH; i++) begin
      tl_nxt[i]   = tl_r[i];
      peak_nxt[i] = peak_r[i];
    end

    for (int i = 0; i < NUM_CH; i++) begin
      if (key_hit && item.reg_addr[CH_W-1:0] == CH_W'(i)) begin
        trig[i]    = !key_r[i] && item.reg_data[KEY_BIT];
        key_nxt[i] = item.reg_data[KEY_BIT];
      end
      if (is_write && item.reg_addr == CARRIER_TL_ADDR[i]) begin
        tl_nxt[i] = item.reg_data[LEVEL_W-1:0];
      end
    end

    if (bd_hit) begin
      bd_nxt = item.reg_data[5:0];
      if (item.reg_data[KEY_BIT]) begin
        trig[6] = trig[6] | drum_edge[4];
        trig[7] = trig[7] | drum_edge[3] | drum_edge[0];
        trig[8] = trig[8] | drum_edge[2] | drum_edge[1];
      end
    end

    case (item.func)
      FUNC_WRITE: begin
        for (int i = 0; i < NUM_CH; i++) begin
          if (trig[i] && lvl[i] > peak_r[i]) peak_nxt[i] = lvl[i];
        end
      end
      FUNC_DECAY: begin
        for (int i = 0; i < NUM_CH; i++) begin
          peak_nxt[i] = (peak_r[i] > decay_step) ? peak_r[i] - decay_step : '0;
        end
      end
      FUNC_MUTE: begin
        if (item.mute_request && !muted_r) begin
          muted_nxt = 1'b1;
          burst     = 1'b1;
        end else begin
          muted_nxt = item.mute_request;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    for (int i = 0; i < NUM_CH; i++) begin
      peaks[i*LEVEL_W +: LEVEL_W] = peak_nxt[i];
    end
  end

  always_comb begin
    res.burst                  = burst;
    res.item.peaks_packed      = peaks;
    res.item.muted_now         = muted_nxt;
    res.item.out_reg           = '0;
    res.item.out_data          = '0;
    res.item.out_valid         = 1'b0;
    res.item.last              = 1'b1;
    if (is_write && !muted_r) begin
      res.item.out_reg   = item.reg_addr;
      res.item.out_data  = item.reg_data;
      res.item.out_valid = 1'b1;
    end else if (burst) begin
      res.item.out_reg   = KEYON_BASE;
      res.item.out_valid = 1'b1;
      res.item.last      = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r   <= '0;
      bd_r    <= '0;
      muted_r <= 1'b0;
      for (int i = 0; i < NUM_CH; i++) begin
        tl_r[i]   <= '0;
        peak_r[i] <= '0;
      end
    end else if (adv) begin
      key_r   <= key_nxt;
      bd_r    <= bd_nxt;
      muted_r <= muted_nxt;
      for (int i = 0; i < NUM_CH; i++) begin
        tl_r[i]   <= tl_nxt[i];
        peak_r[i] <= peak_nxt[i];
      end
    end
  end

endmodule

// ===== rtl/fmpm_outq.sv =====
module fmpm_outq (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load,
  input  fmpm_pkg::step_res_t  res,
  input  logic                 out_stall,
  output logic                 out_valid,
  output fmpm_pkg::out_item_t  out_item,
  output logic                 free
);
  import fmpm_pkg::*;

  logic            out_vld_r;
  out_item_t       out_item_r;
  logic            burst_act_r;
  logic [CH_W-1:0] burst_ch_r, burst_ch_nxt;
  logic            out_take;

  assign out_take     = out_vld_r && !out_stall;
  assign free         = !out_vld_r || (out_take && !burst_act_r);
  assign burst_ch_nxt = burst_ch_r + 1'b1;
  assign out_valid    = out_vld_r;
  assign out_item     = out_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r   <= 1'b0;
      burst_act_r <= 1'b0;
      burst_ch_r  <= '0;
    end else if (load) begin
      out_vld_r   <= 1'b1;
      burst_act_r <= res.burst;
      burst_ch_r  <= '0;
    end else if (out_take) begin
      if (burst_act_r) begin
        burst_ch_r  <= burst_ch_nxt;
        burst_act_r <= burst_ch_nxt != LAST_CH;
      end else begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (load) begin
      out_item_r <= res.item;
    end else if (out_take && burst_act_r) begin
      out_item_r.out_reg <= KEYON_BASE + ADDR_W'(burst_ch_nxt);
      out_item_r.last    <= burst_ch_nxt == LAST_CH;
    end
  end

  a_burst_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    burst_act_r |-> out_vld_r && !out_item_r.last)
    else $error("note-off burst flagged last too early");

  a_burst_addr: assert property (@(posedge clk) disable iff (!rst_n)
    burst_act_r |-> out_item_r.out_reg >= KEYON_BASE && out_item_r.out_reg < KEYON_TOP
                    && out_item_r.out_data == '0 && out_item_r.out_valid)
    else $error("note-off burst write malformed");

  a_burst_ends_on_take: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(burst_act_r) |-> $past(out_take))
    else $error("burst ended without a result taken");

endmodule

// ===== rtl/fm_register_shadow_peak_meter_unit.sv =====
// FM register shadow with peak meters.
//
// Input channel (in_valid / in_stall / in_item): one item per register
// write, decay tick or mute request. An item is taken on a clock edge with
// in_valid high and in_stall low.
// Result channel (out_valid / out_stall / out_item): each item yields one
// result, except a mute that turns muting on, which yields nine note-off
// writes to B0..B8, last set on the ninth only.
// Config port (cfg_valid / cfg_ready / cfg_index / cfg_data): cfg_ready is
// always high; index 0 sets the trigger floor, index 1 the decay step.
// Write it only while no item is in flight.
//
// Path: input register, then result register. Throughput: one item per
// cycle while out_stall is low; a mute-on item holds the result register
// for its nine writes, while one more item waits in the input register.
// Reset (rst_n low, synchronous): shadow, meters and mute flag cleared,
// floor = 8, decay step = 2, both channels empty.
// A stalled receiver holds the result register; the input register still
// takes one item, then in_stall rises.
module fm_register_shadow_peak_meter_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  fmpm_pkg::in_item_t               in_item,
  output logic                             out_valid,
  input  logic                             out_stall,
  output fmpm_pkg::out_item_t              out_item,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [fmpm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [fmpm_pkg::LEVEL_W-1:0]     cfg_data
);
  import fmpm_pkg::*;

  logic               in_vld_r;
  in_item_t           in_item_r;
  logic [LEVEL_W-1:0] peak_floor_r;
  logic [LEVEL_W-1:0] decay_step_r;
  logic               free, adv;
  step_res_t          res;

  // the held item is processed as soon as the result register can take it
  assign adv       = in_vld_r && free;
  assign in_stall  = in_vld_r && !free;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_stall) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_item_r <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      peak_floor_r <= PEAK_FLOOR_RST;
      decay_step_r <= DECAY_STEP_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_PEAK_FLOOR: peak_floor_r <= cfg_data;
        CFG_DECAY_STEP: decay_step_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  fmpm_meter u_meter (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .item       (in_item_r),
    .peak_floor (peak_floor_r),
    .decay_step (decay_step_r),
    .res        (res)
  );

  fmpm_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (adv),
    .res       (res),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_item  (out_item),
    .free      (free)
  );

endmodule
